[src/prf_pkg.sv]
// ---------------------------------------------------------------------------
// prf_pkg: shared types and constants for the paged record fifo
// Field widths, register codes, status codes and the back-end state type.
// ---------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

  // default geometry
  localparam int PANE_COUNT_DEF   = 8;
  localparam int PANE_BYTES_DEF   = 4096;
  localparam int PANE_RECORDS_DEF = 64;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int BLIM_W = 13;
  localparam int RLIM_W = 7;
  localparam int CFG_DATA_W = 13;

  // register reset values
  localparam logic [BLIM_W-1:0] BLIM_RESET = 13'd4096;
  localparam logic [RLIM_W-1:0] RLIM_RESET = 7'd64;

  typedef enum logic {
    CFG_BYTE_LIMIT   = 1'b0,
    CFG_RECORD_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  record_len;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] read_byte;
    logic              read_last;
    logic [LEN_W-1:0]  read_length;
  } result_t;

  typedef enum logic [1:0] {
    BK_EXEC = 2'd0,
    BK_MOVE = 2'd1,
    BK_TAB  = 2'd2,
    BK_DATA = 2'd3
  } back_state_t;

endpackage

`default_nettype wire

[src/prf_if.sv]
// ---------------------------------------------------------------------------
// prf_if: channel interfaces of the paged record fifo
// Input word channel, result word channel and configuration write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface prf_in_if;
  import prf_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prf_out_if;
  import prf_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prf_cfg_if;
  import prf_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/prf_front.sv]
// ---------------------------------------------------------------------------
// prf_front: input stage of the paged record fifo
// Takes input words and holds them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module prf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  prf_pkg::item_t in_data,
  output logic           head_valid,
  output prf_pkg::item_t head,
  input  logic           pop
);
  import prf_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/prf_back.sv]
// ---------------------------------------------------------------------------
// prf_back: execution stage of the paged record fifo
// Runs write and read words against the pane ring, the record tables and
// the byte store, and holds the result word in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module prf_back #(
  parameter int PANE_COUNT   = prf_pkg::PANE_COUNT_DEF,
  parameter int PANE_BYTES   = prf_pkg::PANE_BYTES_DEF,
  parameter int PANE_RECORDS = prf_pkg::PANE_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  prf_pkg::item_t                head,
  output logic                          pop,
  input  logic [prf_pkg::BLIM_W-1:0]    byte_limit,
  input  logic [prf_pkg::RLIM_W-1:0]    record_limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output prf_pkg::result_t              res
);
  import prf_pkg::*;

  localparam int PW   = $clog2(PANE_COUNT);
  localparam int OW   = $clog2(PANE_BYTES);
  localparam int FW   = $clog2(PANE_BYTES + 1);
  localparam int CNW  = $clog2(PANE_RECORDS + 1);
  localparam int BAW  = $clog2(PANE_COUNT * PANE_BYTES);
  localparam int TAW  = $clog2(PANE_COUNT * PANE_RECORDS);
  localparam int CW   = ((FW > BLIM_W) ? FW : BLIM_W) + 1;
  localparam int RCW  = ((CNW > RLIM_W) ? CNW : RLIM_W) + 1;
  localparam logic [PW-1:0] LAST_PANE = PW'(PANE_COUNT - 1);

  // per-pane bookkeeping
  logic [CNW-1:0] cnt  [PANE_COUNT];
  logic [FW-1:0]  fill [PANE_COUNT];
  logic [CNW-1:0] ridx [PANE_COUNT];

  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [LEN_W-1:0] write_offset;
  logic [LEN_W-1:0] write_length;
  logic [LEN_W-1:0] read_offset;
  logic [LEN_W-1:0] cur_len;
  logic [OW-1:0]    cur_start;

  back_state_t state, state_next;

  // memories
  logic [BYTE_W-1:0] byte_mem  [PANE_COUNT * PANE_BYTES];
  logic [LEN_W-1:0]  len_mem   [PANE_COUNT * PANE_RECORDS];
  logic [OW-1:0]     start_mem [PANE_COUNT * PANE_RECORDS];
  logic [BYTE_W-1:0] byte_q;
  logic [LEN_W-1:0]  len_q;
  logic [OW-1:0]     start_q;

  logic           res_free, go, is_write, is_read;
  logic [PW-1:0]  pidx, nx_w, nx_r, wpn;
  logic [CNW-1:0] cnt_p, ridx_p, base_cnt;
  logic [FW-1:0]  fill_p, base_fill;
  logic [CW-1:0]  blim;
  logic [RCW-1:0] rlim;
  logic           bad_len, need_move, full, read_empty;
  logic           commit_first, commit_more, last;
  logic           wr_first, wr_more, rd_move, res_load;
  logic [OW-1:0]  wr_off, rd_off;
  logic           tab_we, tab_re, mem_we, mem_re;
  logic [TAW-1:0] tab_waddr, tab_raddr;
  logic [BAW-1:0] mem_waddr, mem_raddr;
  result_t        res_next;

  // limits in use
  always_comb begin
    if (CW'(byte_limit) < CW'(PANE_BYTES)) begin
      blim = CW'(byte_limit);
    end else begin
      blim = CW'(PANE_BYTES);
    end
    if (record_limit == '0) begin
      rlim = RCW'(1);
    end else if (RCW'(record_limit) < RCW'(PANE_RECORDS)) begin
      rlim = RCW'(record_limit);
    end else begin
      rlim = RCW'(PANE_RECORDS);
    end
  end

  // decisions for the word at the head of the queue
  always_comb begin
    res_free   = !res_valid || res_ready;
    go         = head_valid && res_free;
    is_write   = (head.action == ACT_WRITE);
    is_read    = (head.action == ACT_READ);
    pidx       = (state == BK_EXEC && is_write) ? wp : rp;
    cnt_p      = cnt[pidx];
    fill_p     = fill[pidx];
    ridx_p     = ridx[pidx];
    nx_w       = (wp == LAST_PANE) ? '0 : wp + PW'(1);
    nx_r       = (rp == LAST_PANE) ? '0 : rp + PW'(1);
    bad_len    = (head.record_len == '0) || (CW'(head.record_len) >= blim);
    need_move  = (RCW'(cnt_p) >= rlim) ||
                 ((CW'(fill_p) + CW'(head.record_len)) >= blim);
    full       = need_move && (nx_w == rp);
    wpn        = need_move ? nx_w : wp;
    base_cnt   = need_move ? '0 : cnt_p;
    base_fill  = need_move ? '0 : fill_p;
    commit_first = (head.record_len == LEN_W'(1));
    commit_more  = ((CW'(write_offset) + CW'(1)) >= CW'(write_length));
    read_empty = (ridx_p >= cnt_p);
    last       = ((CW'(read_offset) + CW'(1)) >= CW'(cur_len));
    wr_off     = OW'(CW'(fill_p) + CW'(write_offset));
    rd_off     = OW'(CW'(cur_start) + CW'(read_offset));
    wr_first   = (state == BK_EXEC) && go && is_write && (write_offset == '0) &&
                 !bad_len && !full;
    wr_more    = (state == BK_EXEC) && go && is_write && (write_offset != '0);
    rd_move    = (state == BK_EXEC) && go && is_read && (read_offset == '0) &&
                 read_empty && (rp != wp);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_EXEC: begin
        if (go && is_read) begin
          if (read_offset != '0) begin
            state_next = BK_DATA;
          end else if (!read_empty) begin
            state_next = BK_TAB;
          end else if (rp != wp) begin
            state_next = BK_MOVE;
          end
        end
      end
      BK_MOVE: state_next = read_empty ? BK_EXEC : BK_TAB;
      BK_TAB:  state_next = BK_DATA;
      BK_DATA: state_next = BK_EXEC;
      default: state_next = BK_EXEC;
    endcase
  end

  // memory strobes and result word
  always_comb begin
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    tab_waddr = TAW'(wpn) * TAW'(PANE_RECORDS) + TAW'(base_cnt);
    tab_raddr = TAW'(rp) * TAW'(PANE_RECORDS) + TAW'(ridx_p);
    mem_waddr = BAW'(wp) * BAW'(PANE_BYTES) + BAW'(wr_off);
    mem_raddr = BAW'(rp) * BAW'(PANE_BYTES) + BAW'(rd_off);
    res_load  = 1'b0;
    res_next  = '0;
    case (state)
      BK_EXEC: begin
        if (go && is_write) begin
          res_load = 1'b1;
          if (write_offset == '0) begin
            if (bad_len) begin
              res_next.status = ST_BAD_LEN;
            end else if (full) begin
              res_next.status = ST_FULL;
            end else begin
              tab_we    = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = BAW'(wpn) * BAW'(PANE_BYTES) + BAW'(OW'(base_fill));
              res_next.status = ST_OK;
            end
          end else begin
            mem_we = 1'b1;
            res_next.status = ST_OK;
          end
        end else if (go && is_read) begin
          if (read_offset != '0) begin
            mem_re = 1'b1;
          end else if (!read_empty) begin
            tab_re = 1'b1;
          end else if (rp == wp) begin
            res_load = 1'b1;
            res_next.status = ST_EMPTY;
          end
        end
      end
      BK_MOVE: begin
        if (read_empty) begin
          res_load = 1'b1;
          res_next.status = ST_EMPTY;
        end else begin
          tab_re = 1'b1;
        end
      end
      BK_TAB: begin
        mem_re    = 1'b1;
        mem_raddr = BAW'(rp) * BAW'(PANE_BYTES) + BAW'(start_q);
      end
      BK_DATA: begin
        res_load = 1'b1;
        res_next.status      = ST_OK;
        res_next.read_byte   = byte_q;
        res_next.read_last   = last;
        res_next.read_length = cur_len;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  assign pop = res_load;

  // record tables
  always_ff @(posedge clk) begin
    if (tab_we) begin
      len_mem[tab_waddr]   <= head.record_len;
      start_mem[tab_waddr] <= OW'(base_fill);
    end
    if (tab_re) begin
      len_q   <= len_mem[tab_raddr];
      start_q <= start_mem[tab_raddr];
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_waddr] <= head.data_byte;
    end
    if (mem_re) begin
      byte_q <= byte_mem[mem_raddr];
    end
  end

  // current read record
  always_ff @(posedge clk) begin
    if (state == BK_TAB) begin
      cur_len   <= len_q;
      cur_start <= start_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_EXEC;
      wp           <= '0;
      rp           <= '0;
      write_offset <= '0;
      write_length <= '0;
      read_offset  <= '0;
      res_valid    <= 1'b0;
      for (int i = 0; i < PANE_COUNT; i++) begin
        cnt[i]  <= '0;
        fill[i] <= '0;
        ridx[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      // first word of a record
      if (wr_first) begin
        wp           <= wpn;
        write_length <= head.record_len;
        cnt[wpn]     <= base_cnt + CNW'(commit_first);
        fill[wpn]    <= commit_first ? base_fill + FW'(head.record_len) : base_fill;
        if (need_move) begin
          ridx[wpn] <= '0;
        end
        write_offset <= commit_first ? '0 : LEN_W'(1);
      end
      // later words of a record
      if (wr_more) begin
        if (commit_more) begin
          cnt[wp]      <= cnt_p + CNW'(1);
          fill[wp]     <= fill_p + FW'(write_length);
          write_offset <= '0;
        end else begin
          write_offset <= write_offset + LEN_W'(1);
        end
      end
      // reader steps to the next pane
      if (rd_move) begin
        rp <= nx_r;
      end
      // read word delivered
      if (state == BK_DATA) begin
        if (last) begin
          ridx[rp]    <= ridx_p + CNW'(1);
          read_offset <= '0;
        end else begin
          read_offset <= read_offset + LEN_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/paged_record_fifo.sv]
// ---------------------------------------------------------------------------
// paged_record_fifo: fifo of variable-length byte records in a ring of panes
// Usage:
//   item   - input words; action selects writing one record byte or reading
//            one byte. record_len is sampled on the first byte of a record.
//   result - one result word per input word, in order: status, and on a
//            good read the byte, its last mark and the record length.
//   cfg    - register writes (byte limit, record limit), always ready; write
//            only while the block is idle.
// Steps: a write word is done in the execution stage alone. A read word
//   mid-record takes a byte store read; on a record's first byte, a record
//   table read and then a byte store read; when the reader also steps to
//   the next pane, the pane step comes first. An empty read ends in the
//   execution stage when reader and writer share a pane, else after the
//   pane step.
// A two-entry queue sits in front of the execution stage and the result is
//   registered, so input words are still taken while a result waits. When
//   the receiver stalls, the result holds and the queue fills, then item
//   ready drops.
// Reset empties the ring and sets the limits to 4096 bytes and 64 records;
//   no clearing pass is needed, memory contents are only read once written.
// ---------------------------------------------------------------------------
`default_nettype none

module paged_record_fifo #(
  parameter int PANE_COUNT   = prf_pkg::PANE_COUNT_DEF,
  parameter int PANE_BYTES   = prf_pkg::PANE_BYTES_DEF,
  parameter int PANE_RECORDS = prf_pkg::PANE_RECORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  prf_in_if.sink    item,
  prf_out_if.source result,
  prf_cfg_if.sink   cfg
);
  import prf_pkg::*;

  logic              head_valid;
  item_t             head;
  logic              pop;
  logic [BLIM_W-1:0] byte_limit;
  logic [RLIM_W-1:0] record_limit;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit   <= BLIM_RESET;
      record_limit <= RLIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BYTE_LIMIT:   byte_limit   <= BLIM_W'(cfg.data);
        CFG_RECORD_LIMIT: record_limit <= RLIM_W'(cfg.data);
        default:          byte_limit   <= byte_limit;
      endcase
    end
  end

  // input queue
  prf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_data    (item.data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // execution stage
  prf_back #(
    .PANE_COUNT   (PANE_COUNT),
    .PANE_BYTES   (PANE_BYTES),
    .PANE_RECORDS (PANE_RECORDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .byte_limit   (byte_limit),
    .record_limit (record_limit),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res          (result.data)
  );

endmodule

`default_nettype wire
